// File: rtl/pewq_pkg.sv
// Shared types, constants and helpers for the periodic event wait queues.
`default_nettype none

package pewq_pkg;

  localparam int NUM_SOURCES  = 4;
  localparam int QUEUE_DEPTH  = 16;
  localparam int TASK_ID_BITS = 6;

  localparam int SRC_W    = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
  localparam int QIDX_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int PERIOD_W = 16;
  localparam int TIME_W   = 32;
  localparam int DEV_W    = 2;
  localparam int TASK_W   = 6;
  localparam int PRIO_W   = 6;
  localparam int ENTRY_W  = TASK_ID_BITS + PRIO_W;
  localparam int WQ_AW    = SRC_W + QIDX_W;
  localparam int WQ_DEPTH = 1 << WQ_AW;

  localparam logic ACT_WAIT = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  typedef enum logic [1:0] {
    KIND_WAIT_OK   = 2'd0,
    KIND_WAIT_FULL = 2'd1,
    KIND_RELEASE   = 2'd2,
    KIND_IDLE      = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_DRAIN
  } state_e;

  typedef struct packed {
    logic                action;
    logic [DEV_W-1:0]    device;
    logic [TASK_W-1:0]   task_id;
    logic [PRIO_W-1:0]   task_prio;
    logic [TIME_W-1:0]   now_ms;
  } req_t;

  typedef struct packed {
    logic                valid;
    kind_e               kind;
    logic [TASK_W-1:0]   released_task;
    logic [PRIO_W-1:0]   released_prio;
    logic [DEV_W-1:0]    from_device;
    logic                last;
    logic                dispatch;
  } res_t;

  typedef logic [NUM_SOURCES-1:0][PERIOD_W-1:0] period_arr_t;

  function automatic logic [PERIOD_W-1:0] period_reset(input logic [SRC_W-1:0] s);
    logic [PERIOD_W-1:0] v;
    unique case (2'(s))
      2'd0:    v = PERIOD_W'(100);
      2'd1:    v = PERIOD_W'(200);
      2'd2:    v = PERIOD_W'(500);
      default: v = PERIOD_W'(50);
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: rtl/pewq_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module pewq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/pewq_ctrl.sv
// Sequencer for wait appends, match-time scan and queue drain over the two RAMs.
`default_nettype none

module pewq_ctrl
  import pewq_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire req_t        req_i,
  input  wire period_arr_t period_i,
  output res_t             res_o
);

  state_e state_q, state_d;
  logic [SRC_W-1:0]    src_q;
  logic [TIME_W-1:0]   now_q;
  logic [NUM_SOURCES-1:0] match_q;
  logic [NUM_SOURCES-1:0] mt_valid_q;
  logic [QIDX_W-1:0]   head_q [NUM_SOURCES];
  logic [QIDX_W-1:0]   tail_q [NUM_SOURCES];
  logic [CNT_W-1:0]    cnt_q  [NUM_SOURCES];
  logic                rd_valid_q;
  logic [SRC_W-1:0]    rd_src_q;
  logic                rd_last_q;
  logic                res_valid_q;
  res_t                res_q, res_d;

  logic                wait_go, tick_go, drain_go, idle_go;
  logic                busy;
  logic [SRC_W-1:0]    dev_idx;
  logic                dev_oob, full;

  logic                mt_we;
  logic [SRC_W-1:0]    mt_raddr;
  logic [TIME_W-1:0]   mt_rdata, mt_cur, mt_wdata;
  logic                hit;

  logic                wq_we;
  logic [WQ_AW-1:0]    wq_waddr, wq_raddr;
  logic [ENTRY_W-1:0]  wq_wdata, wq_rdata;

  logic [NUM_SOURCES-1:0] pend, pend_rest;
  logic [SRC_W-1:0]    sel;
  logic                drain_last;

  pewq_ram #(
    .WIDTH(TIME_W),
    .DEPTH(NUM_SOURCES),
    .AW   (SRC_W)
  ) u_match_ram (
    .clk_i  (clk_i),
    .we_i   (mt_we),
    .waddr_i(src_q),
    .wdata_i(mt_wdata),
    .raddr_i(mt_raddr),
    .rdata_o(mt_rdata)
  );

  pewq_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(WQ_DEPTH),
    .AW   (WQ_AW)
  ) u_waiter_ram (
    .clk_i  (clk_i),
    .we_i   (wq_we),
    .waddr_i(wq_waddr),
    .wdata_i(wq_wdata),
    .raddr_i(wq_raddr),
    .rdata_o(wq_rdata)
  );

  assign busy   = (state_q != ST_IDLE) || rd_valid_q;
  assign busy_o = busy;

  // wait path
  assign dev_idx  = SRC_W'(req_i.device);
  assign dev_oob  = 32'(req_i.device) >= NUM_SOURCES;
  assign full     = dev_oob || (cnt_q[dev_idx] == CNT_W'(QUEUE_DEPTH));
  assign wq_we    = wait_go && !full;
  assign wq_waddr = {dev_idx, tail_q[dev_idx]};
  assign wq_wdata = {req_i.task_id[TASK_ID_BITS-1:0], req_i.task_prio};

  // match scan
  assign mt_raddr = (state_q == ST_IDLE) ? '0 : SRC_W'(src_q + 1'b1);
  assign mt_cur   = mt_valid_q[src_q] ? mt_rdata : TIME_W'(period_reset(src_q));
  assign hit      = mt_cur <= now_q;
  assign mt_wdata = now_q + TIME_W'(period_i[src_q]);
  assign mt_we    = (state_q == ST_MATCH) && hit;

  // drain selection
  always_comb begin
    for (int s = 0; s < NUM_SOURCES; s++) begin
      pend[s] = match_q[s] && (cnt_q[s] != '0);
    end
    sel = '0;
    for (int s = NUM_SOURCES - 1; s >= 0; s--) begin
      if (pend[s]) begin
        sel = SRC_W'(s);
      end
    end
    pend_rest      = pend;
    pend_rest[sel] = 1'b0;
    drain_last     = (cnt_q[sel] == CNT_W'(1)) && (pend_rest == '0);
  end

  assign wq_raddr = {sel, head_q[sel]};

  always_comb begin
    state_d  = state_q;
    wait_go  = 1'b0;
    tick_go  = 1'b0;
    drain_go = 1'b0;
    idle_go  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i && !busy) begin
          if (req_i.action == ACT_WAIT) begin
            wait_go = 1'b1;
          end else begin
            tick_go = 1'b1;
            state_d = ST_MATCH;
          end
        end
      end
      ST_MATCH: begin
        if (src_q == SRC_W'(NUM_SOURCES - 1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (pend == '0) begin
          idle_go = 1'b1;
          state_d = ST_IDLE;
        end else begin
          drain_go = 1'b1;
          if (drain_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    res_d               = '0;
    res_d.kind          = KIND_IDLE;
    res_d.last          = 1'b1;
    if (wait_go) begin
      res_d.kind        = full ? KIND_WAIT_FULL : KIND_WAIT_OK;
      res_d.from_device = req_i.device;
    end else if (rd_valid_q) begin
      res_d.kind          = KIND_RELEASE;
      res_d.released_task = TASK_W'(wq_rdata[ENTRY_W-1:PRIO_W]);
      res_d.released_prio = wq_rdata[PRIO_W-1:0];
      res_d.from_device   = DEV_W'(rd_src_q);
      res_d.last          = rd_last_q;
      res_d.dispatch      = rd_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      src_q       <= '0;
      match_q     <= '0;
      mt_valid_q  <= '0;
      rd_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
      for (int s = 0; s < NUM_SOURCES; s++) begin
        head_q[s] <= '0;
        tail_q[s] <= '0;
        cnt_q[s]  <= '0;
      end
    end else begin
      state_q     <= state_d;
      rd_valid_q  <= drain_go;
      res_valid_q <= wait_go || idle_go || rd_valid_q;
      if (tick_go) begin
        src_q   <= '0;
        match_q <= '0;
      end
      if (state_q == ST_MATCH) begin
        match_q[src_q] <= hit;
        if (hit) begin
          mt_valid_q[src_q] <= 1'b1;
        end
        if (src_q != SRC_W'(NUM_SOURCES - 1)) begin
          src_q <= SRC_W'(src_q + 1'b1);
        end
      end
      if (wq_we) begin
        tail_q[dev_idx] <= (tail_q[dev_idx] == QIDX_W'(QUEUE_DEPTH - 1)) ?
                           '0 : QIDX_W'(tail_q[dev_idx] + 1'b1);
        cnt_q[dev_idx]  <= CNT_W'(cnt_q[dev_idx] + 1'b1);
      end
      if (drain_go) begin
        head_q[sel] <= (head_q[sel] == QIDX_W'(QUEUE_DEPTH - 1)) ?
                       '0 : QIDX_W'(head_q[sel] + 1'b1);
        cnt_q[sel]  <= CNT_W'(cnt_q[sel] - 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_go) begin
      now_q <= req_i.now_ms;
    end
    if (drain_go) begin
      rd_src_q  <= sel;
      rd_last_q <= drain_last;
    end
    res_q <= res_d;
  end

  always_comb begin
    res_o       = res_q;
    res_o.valid = res_valid_q;
  end

endmodule

`default_nettype wire

// File: rtl/periodic_event_wait_queues_unit.sv
// Top level: period registers and the wait queue sequencer.
//
//   channel   | handshake                  | payload
//   ----------+----------------------------+---------------------------------------------
//   request   | start / busy               | action, device, task_id, task_prio, now_ms
//   result    | res_strobe_o, one cycle    | kind, released_task, released_prio,
//             |                            | from_device, last, dispatch
//   config    | cfg_we_i, no wait          | cfg_idx_i, cfg_wdata_i
//
// The result of a wait request shows in the next cycle. A tick scans the
// match-time memory at one source per cycle, then drains the matched
// queues at one released task per cycle through the waiter memory read
// port. Reset clears queue pointers and counts; match times read as reset
// periods until first rewritten. No clearing pass. Results cannot be
// stalled.
`default_nettype none

module periodic_event_wait_queues_unit
  import pewq_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic                action_i,
  input  wire logic [DEV_W-1:0]    device_i,
  input  wire logic [TASK_W-1:0]   task_id_i,
  input  wire logic [PRIO_W-1:0]   task_prio_i,
  input  wire logic [TIME_W-1:0]   now_ms_i,
  input  wire logic                cfg_we_i,
  input  wire logic [SRC_W-1:0]    cfg_idx_i,
  input  wire logic [PERIOD_W-1:0] cfg_wdata_i,
  output logic                     res_strobe_o,
  output logic [1:0]               kind_o,
  output logic [TASK_W-1:0]        released_task_o,
  output logic [PRIO_W-1:0]        released_prio_o,
  output logic [DEV_W-1:0]         from_device_o,
  output logic                     last_o,
  output logic                     dispatch_o
);

  period_arr_t period_q;
  req_t        req;
  res_t        res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NUM_SOURCES; s++) begin
        period_q[s] <= period_reset(SRC_W'(s));
      end
    end else if (cfg_we_i && (32'(cfg_idx_i) < NUM_SOURCES)) begin
      period_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  always_comb begin
    req.action    = action_i;
    req.device    = device_i;
    req.task_id   = task_id_i;
    req.task_prio = task_prio_i;
    req.now_ms    = now_ms_i;
  end

  pewq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .req_i   (req),
    .period_i(period_q),
    .res_o   (res)
  );

  assign res_strobe_o    = res.valid;
  assign kind_o          = res.kind;
  assign released_task_o = res.released_task;
  assign released_prio_o = res.released_prio;
  assign from_device_o   = res.from_device;
  assign last_o          = res.last;
  assign dispatch_o      = res.dispatch;

endmodule

`default_nettype wire

// File: rtl/pewq_checker.sv
// Port-level checker for the wait queue unit, bound to the top level.
`default_nettype none

module pewq_checker
  import pewq_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                start,
  input wire logic                busy,
  input wire logic                action_i,
  input wire logic                res_strobe_o,
  input wire logic [1:0]          kind_o,
  input wire logic [TASK_W-1:0]   released_task_o,
  input wire logic                last_o,
  input wire logic                dispatch_o
);

  a_wait_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (action_i == ACT_WAIT) |=>
      res_strobe_o && last_o && !dispatch_o &&
      (kind_o == KIND_WAIT_OK || kind_o == KIND_WAIT_FULL))
    else $error("wait request without its single result");

  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (action_i == ACT_TICK) |=> busy && !res_strobe_o)
    else $error("tick request did not hold busy");

  a_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && dispatch_o |-> last_o && (kind_o == KIND_RELEASE))
    else $error("dispatch outside last release");

  a_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && (kind_o == KIND_IDLE) |->
      last_o && !dispatch_o && (released_task_o == '0))
    else $error("malformed idle tick result");

  a_release_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && (kind_o == KIND_RELEASE) && !last_o |=>
      res_strobe_o && (kind_o == KIND_RELEASE))
    else $error("release run ended without last");

endmodule

bind periodic_event_wait_queues_unit pewq_checker u_pewq_checker (.*);

`default_nettype wire
